// ===== hw/rtl/sysex_dt1_framer_macros.svh =====
// Assertion macros for the DT1 framer.
// Used by the top level only; needs no package.
`ifndef SYSEX_DT1_FRAMER_MACROS_SVH
`define SYSEX_DT1_FRAMER_MACROS_SVH

// same-cycle implication
`define SDF_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define SDF_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hw/rtl/sdf_pkg.sv =====
// Types and constants shared by the DT1 framer modules.
// No dependencies.
package sdf_pkg;

   localparam int BYTE7_W     = 7;
   localparam int CSR_INDEX_W = 1;

   localparam logic [7:0] SYX_START = 8'hF0;
   localparam logic [7:0] MAKER_ID  = 8'h41;
   localparam logic [7:0] CMD_DT1   = 8'h12;
   localparam logic [7:0] SYX_END   = 8'hF7;

   localparam logic [BYTE7_W-1:0] DEVICE_ID_RESET = 7'd16;
   localparam logic [BYTE7_W-1:0] MODEL_ID_RESET  = 7'd66;

   localparam logic [CSR_INDEX_W-1:0] CSR_DEVICE_ID = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_MODEL_ID  = 1'b1;

   typedef struct packed {
      logic [23:0]        address;
      logic [BYTE7_W-1:0] data_byte;
      logic               last_byte;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       end_of_message;
   } rsp_type;

   // one classified item, as queued between front and back
   typedef struct packed {
      logic               first;
      logic               last;
      logic [BYTE7_W-1:0] addr_hi;
      logic [BYTE7_W-1:0] addr_mid;
      logic [BYTE7_W-1:0] addr_lo;
      logic [BYTE7_W-1:0] data;
   } cmd_type;

   typedef enum logic [3:0] {
      PH_SOF,
      PH_MAKER,
      PH_DEV,
      PH_MODEL,
      PH_CMD,
      PH_ADDR_HI,
      PH_ADDR_MID,
      PH_ADDR_LO,
      PH_DATA,
      PH_SUM,
      PH_EOF
   } phase_type;

endpackage

// ===== hw/rtl/sdf_front.sv =====
// Front end of the DT1 framer: takes input transfers, tracks message
// boundaries and pushes classified commands. Depends on sdf_pkg.
module sdf_front import sdf_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   input  logic    q_full,
   output logic    q_push,
   output cmd_type q_cmd
);

   logic in_message_ff;
   logic in_message_in;

   assign req_stall = q_full;
   assign q_push    = req_valid && !q_full;

   always_comb begin
      q_cmd.first    = !in_message_ff;
      q_cmd.last     = req_data.last_byte;
      q_cmd.addr_hi  = req_data.address[22:16];
      q_cmd.addr_mid = req_data.address[14:8];
      q_cmd.addr_lo  = req_data.address[6:0];
      q_cmd.data     = req_data.data_byte;

      in_message_in = in_message_ff;
      if (q_push) begin
         in_message_in = !req_data.last_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_message_ff <= 1'b0;
      end else begin
         in_message_ff <= in_message_in;
      end
   end

endmodule

// ===== hw/rtl/sdf_queue.sv =====
// Small register queue between front and back of the DT1 framer.
// Depends on sdf_pkg.
module sdf_queue import sdf_pkg::*; #(
   parameter int DEPTH = 4
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_cmd,
   input  logic    pop,
   output logic    full,
   output logic    head_valid,
   output cmd_type head_cmd
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   cmd_type          entries_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign full       = (count_ff == CNT_W'(DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_cmd   = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      unique case ({push, pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ===== hw/rtl/sdf_back.sv =====
// Back end of the DT1 framer: walks each queued command through its
// header, payload and trailer bytes into the output register. Depends on sdf_pkg.
module sdf_back import sdf_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic [BYTE7_W-1:0] device_id,
   input  logic [BYTE7_W-1:0] model_id,
   input  logic               q_valid,
   input  cmd_type            q_cmd,
   output logic               q_pop,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output rsp_type            rsp_data
);

   phase_type          phase_ff, phase_in, cur, nxt;
   logic               mid_ff, mid_in;
   logic [BYTE7_W-1:0] sum_ff, sum_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_data_ff, rsp_data_in;
   rsp_type            emit_data;
   logic               emit, done;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_comb begin
      // a command not yet started begins at the header or straight at its payload
      if (mid_ff) begin
         cur = phase_ff;
      end else begin
         cur = q_cmd.first ? PH_SOF : PH_DATA;
      end

      emit_data.end_of_message = 1'b0;
      emit_data.out_byte       = SYX_START;
      sum_in                   = sum_ff;
      nxt                      = PH_SOF;
      unique case (cur)
         PH_SOF: begin
            emit_data.out_byte = SYX_START;
            nxt = PH_MAKER;
         end
         PH_MAKER: begin
            emit_data.out_byte = MAKER_ID;
            nxt = PH_DEV;
         end
         PH_DEV: begin
            emit_data.out_byte = {1'b0, device_id};
            nxt = PH_MODEL;
         end
         PH_MODEL: begin
            emit_data.out_byte = {1'b0, model_id};
            nxt = PH_CMD;
         end
         PH_CMD: begin
            emit_data.out_byte = CMD_DT1;
            nxt = PH_ADDR_HI;
         end
         PH_ADDR_HI: begin
            emit_data.out_byte = {1'b0, q_cmd.addr_hi};
            sum_in = q_cmd.addr_hi;
            nxt = PH_ADDR_MID;
         end
         PH_ADDR_MID: begin
            emit_data.out_byte = {1'b0, q_cmd.addr_mid};
            sum_in = sum_ff + q_cmd.addr_mid;
            nxt = PH_ADDR_LO;
         end
         PH_ADDR_LO: begin
            emit_data.out_byte = {1'b0, q_cmd.addr_lo};
            sum_in = sum_ff + q_cmd.addr_lo;
            nxt = PH_DATA;
         end
         PH_DATA: begin
            emit_data.out_byte = {1'b0, q_cmd.data};
            sum_in = sum_ff + q_cmd.data;
            nxt = PH_SUM;
         end
         PH_SUM: begin
            // two's complement mod 128 is the checksum
            emit_data.out_byte = {1'b0, BYTE7_W'(~sum_ff + 1'b1)};
            nxt = PH_EOF;
         end
         PH_EOF: begin
            emit_data.out_byte       = SYX_END;
            emit_data.end_of_message = 1'b1;
            nxt = PH_SOF;
         end
         default: begin
            emit_data.out_byte = SYX_START;
            nxt = PH_SOF;
         end
      endcase

      done  = ((cur == PH_DATA) && !q_cmd.last) || (cur == PH_EOF);
      emit  = q_valid && (!rsp_valid_ff || !rsp_stall);
      q_pop = emit && done;

      phase_in     = phase_ff;
      mid_in       = mid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (emit) begin
         phase_in     = nxt;
         mid_in       = !done;
         rsp_data_in  = emit_data;
         rsp_valid_in = 1'b1;
      end else begin
         sum_in = sum_ff;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_SOF;
         mid_ff       <= 1'b0;
         sum_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         mid_ff       <= mid_in;
         sum_ff       <= sum_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ===== hw/rtl/sysex_dt1_framer.sv =====
// DT1 system-exclusive framer, top level.
// Holds the ID registers and joins sdf_front, sdf_queue and sdf_back;
// depends on sdf_pkg and sysex_dt1_framer_macros.svh.
//
// Usage: each req transfer carries one payload byte, the message address
// (read only on a message's first byte) and a last flag. The rsp channel
// delivers the framed stream one byte per transfer: F0 41 device model 12,
// three address bytes, the payloads, the checksum and F7, the F7 flagged
// with end_of_message. The csr port writes device_id (index 0) and
// model_id (index 1); write it only while no message is in flight.
// An item is written into the queue, then its first byte into the output register.
// Throughput: one output byte per cycle while rsp_stall is low, so mid-message
// items go through at one per cycle; an item that opens a message yields 9
// output bytes and a last item 3 (11 for a one-byte message).
// A QUEUE_DEPTH-entry queue decouples input from the sequencer; req_stall
// rises only when it is full. While rsp_stall is high and a byte is valid, the
// output byte holds and the sequencer waits. Reset empties the queue, closes any open
// message and restores device_id 10h and model_id 42h.
`include "sysex_dt1_framer_macros.svh"

module sysex_dt1_framer import sdf_pkg::*; #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  req_type                req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output rsp_type                rsp_data,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [BYTE7_W-1:0]     csr_wdata
);

   logic [BYTE7_W-1:0] device_id_ff, device_id_in;
   logic [BYTE7_W-1:0] model_id_ff, model_id_in;
   logic               q_push, q_pop, q_full, q_valid;
   cmd_type            q_in_cmd, q_head_cmd;

   always_comb begin
      device_id_in = device_id_ff;
      model_id_in  = model_id_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_DEVICE_ID: device_id_in = csr_wdata;
            CSR_MODEL_ID:  model_id_in  = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         device_id_ff <= DEVICE_ID_RESET;
         model_id_ff  <= MODEL_ID_RESET;
      end else begin
         device_id_ff <= device_id_in;
         model_id_ff  <= model_id_in;
      end
   end

   sdf_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .q_full    (q_full),
      .q_push    (q_push),
      .q_cmd     (q_in_cmd)
   );

   sdf_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_cmd   (q_in_cmd),
      .pop        (q_pop),
      .full       (q_full),
      .head_valid (q_valid),
      .head_cmd   (q_head_cmd)
   );

   sdf_back u_back (
      .clock     (clock),
      .reset     (reset),
      .device_id (device_id_ff),
      .model_id  (model_id_ff),
      .q_valid   (q_valid),
      .q_cmd     (q_head_cmd),
      .q_pop     (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   `SDF_ASSERT_NOW(a_eom_on_f7, clock, reset, rsp_valid && rsp_data.end_of_message, rsp_data.out_byte == SYX_END, "end_of_message on a byte other than F7")
   `SDF_ASSERT_NEXT(a_push_lands, clock, reset, req_valid && !req_stall, q_valid, "accepted transfer not visible in queue")
   `SDF_ASSERT_NOW(a_pop_nonempty, clock, reset, q_pop, q_valid, "queue popped while empty")
   `SDF_ASSERT_NOW(a_reset_clears, clock, reset, $past(reset), !rsp_valid && q_valid == 1'b0, "output or queue not empty after reset")

endmodule

// ===== verif/sdf_stream_checker.sv =====
`timescale 1ns / 100ps
// Scoreboard for the DT1 framer: watches the req, rsp and csr ports, predicts
// the framed byte stream and compares every rsp transfer. Depends on sdf_pkg.
module sdf_stream_checker import sdf_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_stall,
   input  req_type                req_data,
   input  logic                   rsp_valid,
   input  logic                   rsp_stall,
   input  rsp_type                rsp_data,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [BYTE7_W-1:0]     csr_wdata,
   output int                     mismatch_count,
   output int                     bytes_outstanding,
   output int                     bytes_checked,
   output int                     messages_closed
);

   logic [BYTE7_W-1:0] device_id_q;
   logic [BYTE7_W-1:0] model_id_q;
   logic [BYTE7_W-1:0] sum_q;
   logic               msg_open;
   rsp_type            expected_stream[$];

   function automatic rsp_type stream_byte(input logic [7:0] b, input logic eom);
      rsp_type r;
      r.out_byte       = b;
      r.end_of_message = eom;
      return r;
   endfunction

   // Appends the bytes one payload transfer produces to the expected stream.
   task automatic frame_payload(input req_type item);
      logic [BYTE7_W-1:0] addr_hi;
      logic [BYTE7_W-1:0] addr_mid;
      logic [BYTE7_W-1:0] addr_lo;
      logic [BYTE7_W-1:0] checksum;
      addr_hi  = item.address[22:16];
      addr_mid = item.address[14:8];
      addr_lo  = item.address[6:0];
      if (!msg_open) begin
         expected_stream.push_back(stream_byte(SYX_START, 1'b0));
         expected_stream.push_back(stream_byte(MAKER_ID, 1'b0));
         expected_stream.push_back(stream_byte({1'b0, device_id_q}, 1'b0));
         expected_stream.push_back(stream_byte({1'b0, model_id_q}, 1'b0));
         expected_stream.push_back(stream_byte(CMD_DT1, 1'b0));
         expected_stream.push_back(stream_byte({1'b0, addr_hi}, 1'b0));
         expected_stream.push_back(stream_byte({1'b0, addr_mid}, 1'b0));
         expected_stream.push_back(stream_byte({1'b0, addr_lo}, 1'b0));
         sum_q    = addr_hi + addr_mid + addr_lo;
         msg_open = 1'b1;
      end
      expected_stream.push_back(stream_byte({1'b0, item.data_byte}, 1'b0));
      sum_q = sum_q + item.data_byte;
      if (item.last_byte) begin
         // 7-bit wrap makes 128 - sum the same as the negated sum
         checksum = 7'd0 - sum_q;
         expected_stream.push_back(stream_byte({1'b0, checksum}, 1'b0));
         expected_stream.push_back(stream_byte(SYX_END, 1'b1));
         msg_open = 1'b0;
         sum_q    = '0;
      end
   endtask

   always @(posedge clock) begin : monitor
      rsp_type want;
      if (reset) begin
         device_id_q     = DEVICE_ID_RESET;
         model_id_q      = MODEL_ID_RESET;
         sum_q           = '0;
         msg_open        = 1'b0;
         mismatch_count  = 0;
         bytes_checked   = 0;
         messages_closed = 0;
         expected_stream.delete();
      end else begin
         // rsp first: a byte leaving now is older than any req taken now
         if (rsp_valid && !rsp_stall) begin
            if (expected_stream.size() == 0) begin
               $error("unexpected rsp transfer: out_byte %h, end_of_message %b",
                      rsp_data.out_byte, rsp_data.end_of_message);
               mismatch_count++;
            end else begin
               want = expected_stream.pop_front();
               if (rsp_data.out_byte !== want.out_byte) begin
                  $error("out_byte mismatch: expected %h, actual %h",
                         want.out_byte, rsp_data.out_byte);
                  mismatch_count++;
               end
               if (rsp_data.end_of_message !== want.end_of_message) begin
                  $error("end_of_message mismatch: expected %b, actual %b",
                         want.end_of_message, rsp_data.end_of_message);
                  mismatch_count++;
               end
               bytes_checked++;
               if (want.end_of_message)
                  messages_closed++;
            end
         end
         if (csr_we) begin
            case (csr_index)
               CSR_DEVICE_ID: device_id_q = csr_wdata;
               CSR_MODEL_ID:  model_id_q  = csr_wdata;
               default: ;
            endcase
         end
         if (req_valid && !req_stall)
            frame_payload(req_data);
      end
      bytes_outstanding = expected_stream.size();
   end

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 100ps
// Top of the DT1 framer testbench: clock, reset, stimulus and verdict.
// Depends on sdf_pkg, sysex_dt1_framer and sdf_stream_checker.
module tb_top;
   import sdf_pkg::*;

   localparam int IDLE_LIMIT    = 2000;
   localparam int RANDOM_PHASES = 9;
   localparam int PHASE_ITEMS   = 50;

   logic                   clock     = 1'b0;
   logic                   reset     = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   req_type                req_data  = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   rsp_type                rsp_data;
   logic                   csr_we    = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [BYTE7_W-1:0]     csr_wdata = '0;

   int   mismatch_count;
   int   bytes_outstanding;
   int   bytes_checked;
   int   messages_closed;
   int   items_sent  = 0;
   int   csr_writes  = 0;
   int   idle_cycles = 0;
   int   stall_left  = 0;
   logic steady      = 1'b0;
   logic open_msg    = 1'b0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   sysex_dt1_framer u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   sdf_stream_checker u_checker (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_data          (req_data),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_data          (rsp_data),
      .csr_we            (csr_we),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .mismatch_count    (mismatch_count),
      .bytes_outstanding (bytes_outstanding),
      .bytes_checked     (bytes_checked),
      .messages_closed   (messages_closed)
   );

   // sink backpressure in random-length bursts
   always @(negedge clock) begin
      if (reset || steady) begin
         rsp_stall  = 1'b0;
         stall_left = 0;
      end else if (stall_left > 0) begin
         rsp_stall = 1'b1;
         stall_left--;
      end else if ($urandom_range(0, 4) == 0) begin
         rsp_stall  = 1'b1;
         stall_left = $urandom_range(0, 6);
      end else begin
         rsp_stall = 1'b0;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   task automatic send_byte(input logic [23:0] addr, input logic [BYTE7_W-1:0] data,
                            input logic last);
      int gap;
      @(negedge clock);
      if (!steady && $urandom_range(0, 3) == 0) begin
         gap       = $urandom_range(1, 7);
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_data.address   = addr;
      req_data.data_byte = data;
      req_data.last_byte = last;
      req_valid          = 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      items_sent++;
      open_msg = !last;
   endtask

   task automatic send_message(input int len);
      for (int i = 0; i < len; i++)
         send_byte(24'($urandom), 7'($urandom_range(0, 127)), i == len - 1);
   endtask

   // stop sending and wait until every predicted byte has gone out
   task automatic drain();
      @(negedge clock);
      req_valid = 1'b0;
      while (bytes_outstanding != 0) @(negedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [BYTE7_W-1:0] val);
      @(negedge clock);
      csr_we    = 1'b1;
      csr_index = idx;
      csr_wdata = val;
      @(negedge clock);
      csr_we = 1'b0;
      csr_writes++;
   endtask

   initial begin
      int len;
      int phase_items;
      repeat (8) @(negedge clock);
      reset = 1'b0;

      // one-byte messages at the field extremes, reset IDs
      send_byte(24'h000000, 7'h00, 1'b1);
      send_byte(24'hFFFFFF, 7'h7F, 1'b1);
      send_byte(24'h808080, 7'h01, 1'b1);   // bit 7 of each address byte drops out
      // address after the header is ignored
      send_byte(24'h400000, 7'h7F, 1'b0);
      send_byte(24'hFFFFFF, 7'h7F, 1'b0);
      send_byte(24'h000000, 7'h41, 1'b1);
      // ID write with a message open only shows at the next header
      send_byte(24'h123456, 7'h55, 1'b0);
      drain();
      write_reg(CSR_DEVICE_ID, 7'h00);
      write_reg(CSR_MODEL_ID, 7'h7F);
      send_byte(24'h654321, 7'h2A, 1'b0);
      send_byte(24'hABCDEF, 7'h00, 1'b1);
      send_byte(24'h7F0000, 7'h10, 1'b1);
      drain();
      write_reg(CSR_DEVICE_ID, 7'h7F);
      write_reg(CSR_MODEL_ID, 7'h00);
      send_byte(24'h0A0B0C, 7'h33, 1'b1);
      send_message(3);

      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         drain();
         write_reg(CSR_DEVICE_ID, 7'($urandom_range(0, 127)));
         if ($urandom_range(0, 3) != 0)
            write_reg(CSR_MODEL_ID, 7'($urandom_range(0, 127)));
         if (phase == RANDOM_PHASES - 1)
            steady = 1'b1;
         phase_items = 0;
         while (phase_items < PHASE_ITEMS) begin
            if ($urandom_range(0, 4) == 0) begin
               // stray transfer with a random last flag
               send_byte(24'($urandom), 7'($urandom_range(0, 127)), 1'($urandom));
               phase_items++;
            end else begin
               len = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 24)
                                                 : $urandom_range(1, 8);
               send_message(len);
               phase_items += len;
            end
         end
         if (open_msg)
            send_byte(24'($urandom), 7'($urandom_range(0, 127)), 1'b1);
      end

      drain();
      repeat (8) @(negedge clock);
      $display("summary: %0d payload transfers in %0d messages, %0d csr writes",
               items_sent, messages_closed, csr_writes);
      $display("summary: %0d framed bytes compared, %0d mismatches",
               bytes_checked, mismatch_count);
      if (mismatch_count == 0 && bytes_outstanding == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
